### sv/alu_register_file_execute_core_defines.svh
// assertion macros used by the execute core top level
`ifndef ALU_REGISTER_FILE_EXECUTE_CORE_DEFINES_SVH
`define ALU_REGISTER_FILE_EXECUTE_CORE_DEFINES_SVH

// same-cycle implication, checked at each rising edge outside reset
`define ARFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("execute core check failed");

// next-cycle implication
`define ARFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("execute core check failed");

`endif

### sv/arfe_pkg.sv
// types and constants of the execute core
package arfe_pkg;

	localparam int REG_COUNT   = 8;
	localparam int REG_IDX_W   = $clog2(REG_COUNT);
	localparam int DATA_W      = 16;
	localparam int FLAG_W      = 5;
	localparam int MASK_W      = 5;
	localparam int KIND_W      = 5;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 24;
	localparam int S_USED_W    = 2 * REG_IDX_W + DATA_W + MASK_W;
	localparam int M_USED_W    = DATA_W + FLAG_W;

	localparam logic [DATA_W-1:0] SIGN_BIT = 16'h8000;
	localparam logic [7:0]        BYTE_ONES = 8'hFF;
	localparam logic [7:0]        BYTE_ZERO = 8'h00;

	typedef enum logic [KIND_W-1:0] {
		K_ADD   = 5'd0,
		K_SUB   = 5'd1,
		K_ADDC  = 5'd2,
		K_SUBC  = 5'd3,
		K_CMP   = 5'd4,
		K_XOR   = 5'd5,
		K_AND   = 5'd6,
		K_OR    = 5'd7,
		K_BIT   = 5'd8,
		K_BIC   = 5'd9,
		K_BIS   = 5'd10,
		K_MOV   = 5'd11,
		K_SWAP  = 5'd12,
		K_SWPB  = 5'd13,
		K_SRA   = 5'd14,
		K_RRC   = 5'd15,
		K_SXT   = 5'd16,
		K_MOVLZ = 5'd17,
		K_MOVL  = 5'd18,
		K_MOVLS = 5'd19,
		K_MOVH  = 5'd20,
		K_SETCC = 5'd21,
		K_CLRCC = 5'd22
	} kind_t;

	// bit 0 carry up to bit 4 sleep, same layout as the flag mask
	typedef struct packed {
		logic sleep;
		logic overflow;
		logic negative;
		logic zero;
		logic carry;
	} flags_t;

	typedef struct packed {
		kind_t                 kind;
		logic [REG_IDX_W-1:0]  dest_reg;
		logic [REG_IDX_W-1:0]  source_reg;
		logic [DATA_W-1:0]     operand_value;
		logic [MASK_W-1:0]     flag_mask;
	} op_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              wr_dest;
		logic              wr_source;
		flags_t            flags;
	} alu_res_t;

endpackage

### sv/arfe_alu.sv
// combinational alu: result value, register write enables and new flags
module arfe_alu import arfe_pkg::*; (
	input  op_t               op,
	input  logic [DATA_W-1:0] dest_val,
	input  logic [DATA_W-1:0] source_val,
	input  flags_t            flags,
	output alu_res_t          res
);

	logic [DATA_W-1:0] a;
	logic [DATA_W-1:0] b;
	logic              cin;
	logic [DATA_W:0]   sum;
	logic [DATA_W:0]   diff;
	logic [DATA_W-1:0] r;
	logic              add_v;
	logic              sub_v;

	assign a    = dest_val;
	assign b    = op.operand_value;
	assign cin  = ((op.kind == K_ADDC) || (op.kind == K_SUBC)) ? flags.carry : 1'b0;
	assign sum  = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, cin};
	assign diff = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, cin};
	assign add_v = ((~(a ^ b) & (a ^ sum[DATA_W-1:0])) & SIGN_BIT) != '0;
	assign sub_v = (((a ^ b) & (a ^ diff[DATA_W-1:0])) & SIGN_BIT) != '0;

	always_comb begin
		res.value     = a;
		res.wr_dest   = 1'b0;
		res.wr_source = 1'b0;
		res.flags     = flags;
		r             = '0;
		unique case (op.kind)
			K_ADD, K_ADDC: begin
				r = sum[DATA_W-1:0];
				res.value = r;
				res.wr_dest = 1'b1;
				res.flags.carry = sum[DATA_W];
				res.flags.overflow = add_v;
				res.flags.zero = (r == '0);
				res.flags.negative = r[DATA_W-1];
			end
			K_SUB, K_SUBC, K_CMP: begin
				r = diff[DATA_W-1:0];
				res.value = (op.kind == K_CMP) ? a : r;
				res.wr_dest = (op.kind != K_CMP);
				res.flags.carry = diff[DATA_W];
				res.flags.overflow = sub_v;
				res.flags.zero = (r == '0);
				res.flags.negative = r[DATA_W-1];
			end
			K_XOR, K_AND, K_OR, K_BIT, K_BIC, K_BIS, K_MOV,
			K_SWPB, K_SRA, K_RRC, K_SXT: begin
				unique case (op.kind)
					K_XOR:        r = a ^ b;
					K_AND, K_BIT: r = a & b;
					K_OR, K_BIS:  r = a | b;
					K_BIC:        r = a & ~b;
					K_MOV:        r = b;
					K_SWPB:       r = {a[7:0], a[15:8]};
					K_SRA:        r = {a[DATA_W-1], a[DATA_W-1:1]};
					K_RRC:        r = {flags.carry, a[DATA_W-1:1]};
					default:      r = {{8{a[7]}}, a[7:0]};
				endcase
				res.value = (op.kind == K_BIT) ? a : r;
				res.wr_dest = (op.kind != K_BIT);
				if (op.kind == K_RRC) begin
					res.flags.carry = a[0];
				end
				res.flags.zero = (r == '0);
				res.flags.negative = r[DATA_W-1];
			end
			K_SWAP: begin
				res.value = (op.dest_reg != op.source_reg) ? source_val : a;
				res.wr_dest = (op.dest_reg != op.source_reg);
				res.wr_source = (op.dest_reg != op.source_reg);
			end
			K_MOVLZ: begin
				res.value = {BYTE_ZERO, b[7:0]};
				res.wr_dest = 1'b1;
			end
			K_MOVL: begin
				res.value = {a[15:8], b[7:0]};
				res.wr_dest = 1'b1;
			end
			K_MOVLS: begin
				res.value = {BYTE_ONES, b[7:0]};
				res.wr_dest = 1'b1;
			end
			K_MOVH: begin
				res.value = {b[7:0], a[7:0]};
				res.wr_dest = 1'b1;
			end
			K_SETCC: res.flags = flags_t'(flags | op.flag_mask);
			K_CLRCC: res.flags = flags_t'(flags & ~op.flag_mask);
			default: begin
			end
		endcase
	end

endmodule

### sv/alu_register_file_execute_core.sv
// top level of the execute core: input stage, register file, flags and result register
//
// input channel s_*: one operation per item, the kind code on s_tuser and the
// register indexes, operand and flag mask on s_tdata. output channel m_*: one
// result per item, the destination register's new value and the five flags.
// an accepted item waits in the input stage, is executed there against the
// register file and flags, and its result is registered in the output
// register as soon as that register is free or is being read by the receiver.
// throughput is one item per cycle unless the receiver stalls; the register
// file and flags are updated in the same cycle the result is registered, so
// the following item sees them. when the receiver stalls the result holds and
// one further item may wait in the input stage before s_tready drops.
// reset clears all eight registers, the flags and both valid bits.
`include "alu_register_file_execute_core_defines.svh"

module alu_register_file_execute_core import arfe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// dest_reg, source_reg, operand_value, flag_mask, zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// kind
	input  logic [KIND_W-1:0]    s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// dest_value, carry, zero, negative, overflow, sleep, zero fill
	output logic [M_TDATA_W-1:0] m_tdata
);

	op_t                  op_in;
	op_t                  op_s1;
	logic                 valid_s1;
	logic                 adv_s1;
	logic                 out_free;
	logic                 out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic [DATA_W-1:0]    rf_q [REG_COUNT];
	flags_t               flags_q;
	logic [DATA_W-1:0]    dest_val;
	logic [DATA_W-1:0]    source_val;
	alu_res_t             res;

	assign op_in.kind          = kind_t'(s_tuser);
	assign op_in.dest_reg      = s_tdata[REG_IDX_W-1:0];
	assign op_in.source_reg    = s_tdata[2*REG_IDX_W-1:REG_IDX_W];
	assign op_in.operand_value = s_tdata[2*REG_IDX_W+DATA_W-1:2*REG_IDX_W];
	assign op_in.flag_mask     = s_tdata[S_USED_W-1:2*REG_IDX_W+DATA_W];

	assign out_free = !out_valid_q || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= op_in;
		end
	end

	assign dest_val   = rf_q[op_s1.dest_reg];
	assign source_val = rf_q[op_s1.source_reg];

	arfe_alu u_alu (
		.op         (op_s1),
		.dest_val   (dest_val),
		.source_val (source_val),
		.flags      (flags_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_q[i] <= '0;
			end
			flags_q <= '0;
		end else if (adv_s1) begin
			if (res.wr_dest) begin
				rf_q[op_s1.dest_reg] <= res.value;
			end
			if (res.wr_source) begin
				rf_q[op_s1.source_reg] <= dest_val;
			end
			flags_q <= res.flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= {{(M_TDATA_W-M_USED_W){1'b0}}, res.flags, res.value};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`ARFE_ASSERT_NEXT(a_adv_gives_result, clk, arst_n, adv_s1, m_tvalid)
	`ARFE_ASSERT_NEXT(a_stage_holds, clk, arst_n,
		valid_s1 && !out_free, valid_s1 && $stable(op_s1))
	`ARFE_ASSERT_NEXT(a_cmp_keeps_reg, clk, arst_n,
		adv_s1 && (op_s1.kind == K_CMP),
		rf_q[$past(op_s1.dest_reg)] == $past(dest_val))
	`ARFE_ASSERT_NEXT(a_swap_exchanges, clk, arst_n,
		adv_s1 && (op_s1.kind == K_SWAP) && (op_s1.dest_reg != op_s1.source_reg),
		(rf_q[$past(op_s1.dest_reg)] == $past(source_val)) &&
		(rf_q[$past(op_s1.source_reg)] == $past(dest_val)))

endmodule
